// ----- sv/adpcm_pkg.sv -----
`default_nettype none

package adpcm_pkg;

  // Block layout
  localparam logic [2:0] LAST_WORD_IDX = 3'd6;   // seventh data word of a block
  localparam logic [1:0] LAST_NIB_IDX  = 2'd3;   // fourth nibble of a data word

  // Header limits
  localparam logic [3:0] SHIFT_LIMIT   = 4'd12;
  localparam logic [3:0] SHIFT_SUBST   = 4'd9;
  localparam logic [2:0] FILTER_LIMIT  = 3'd4;

  // Saturation bounds of the 20-bit sum
  localparam logic signed [19:0] SAT_HI = 20'sd32767;
  localparam logic signed [19:0] SAT_LO = -20'sd32768;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_POS,
    ST_MUL_NEG,
    ST_FINISH
  } state_t;

  // Operation of the shared multiply unit
  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_POS,
    MAC_NEG,
    MAC_FINISH
  } mac_op_t;

  // Control from the sequencer to the multiply unit
  typedef struct packed {
    mac_op_t    op;
    logic [3:0] nibble;
    logic [3:0] shift;
    logic [2:0] filter;
    logic       commit;
  } mac_ctl_t;

  // Side information that goes with each sample
  typedef struct packed {
    logic       commit;
    logic [2:0] loop_flags;
    logic       last_of_word;
    logic       block_done;
  } out_info_t;

  // Weight of the newest history sample
  function automatic logic signed [7:0] coef_pos(input logic [2:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      3'd0:    c = 8'sd0;
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // Weight of the older history sample
  function automatic logic signed [7:0] coef_neg(input logic [2:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      3'd0:    c = 8'sd0;
      3'd1:    c = 8'sd0;
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/adpcm_in_if.sv -----
`default_nettype none

interface adpcm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] word;
  logic        is_header;

  modport source (output valid, output word, output is_header, input ready);
  modport sink   (input valid, input word, input is_header, output ready);
endinterface

`default_nettype wire

// ----- sv/adpcm_out_if.sv -----
`default_nettype none

interface adpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               loop_end;
  logic               loop_repeat;
  logic               loop_start;
  logic               last_of_word;
  logic               block_done;

  modport source (
    output valid, output sample, output loop_end, output loop_repeat,
    output loop_start, output last_of_word, output block_done, input ready
  );
  modport sink (
    input valid, input sample, input loop_end, input loop_repeat,
    input loop_start, input last_of_word, input block_done, output ready
  );
endinterface

`default_nettype wire

// ----- sv/adpcm_block_decoder.sv -----
// Header word: taken while the sequencer is idle, gives no sample.
// Data word: each of its four samples runs through MUL_POS, MUL_NEG and FINISH on the
// shared multiplier and is registered on commit; the next word is taken once idle again.
// A stalled output holds the sequencer in its final step of the waiting sample.
// Synchronous active-high reset clears header state, history, word count and output valid.
`default_nettype none

module adpcm_block_decoder (
  input  wire logic   clk,
  input  wire logic   rst,
  adpcm_in_if.sink    in_ch,
  adpcm_out_if.source out_ch
);
  import adpcm_pkg::*;

  mac_ctl_t           ctl;
  out_info_t          info;
  logic signed [15:0] sample_val;
  logic               slot_free;

  logic               out_valid;
  logic signed [15:0] out_sample;
  logic [2:0]         out_flags;
  logic               out_last;
  logic               out_done;

  assign slot_free = !out_valid || out_ch.ready;

  adpcm_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_word      (in_ch.word),
    .in_is_header (in_ch.is_header),
    .in_ready     (in_ch.ready),
    .slot_free    (slot_free),
    .ctl          (ctl),
    .info         (info)
  );

  adpcm_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sample_val (sample_val)
  );

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (info.commit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (info.commit) begin
      out_sample <= sample_val;
      out_flags  <= info.loop_flags;
      out_last   <= info.last_of_word;
      out_done   <= info.block_done;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sample       = out_sample;
  assign out_ch.loop_end     = out_flags[0];
  assign out_ch.loop_repeat  = out_flags[1];
  assign out_ch.loop_start   = out_flags[2];
  assign out_ch.last_of_word = out_last;
  assign out_ch.block_done   = out_done;

`ifndef SYNTHESIS
  // No sample is produced while the input side is open
  a_commit_not_idle: assert property (@(posedge clk) disable iff (rst)
    info.commit |-> !in_ch.ready)
    else $error("sample committed while input ready");

  // A sample never overwrites one that is still waiting
  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    info.commit |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten");

  // End of block falls on the last sample of a word
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.block_done) |-> out_ch.last_of_word)
    else $error("block_done without last_of_word");

  // After the last sample of a word the input side opens again
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (info.commit && info.last_of_word) |=> in_ch.ready)
    else $error("input not reopened after last sample");
`endif

endmodule

`default_nettype wire

// ----- sv/adpcm_mac.sv -----
`default_nettype none

module adpcm_mac (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire adpcm_pkg::mac_ctl_t ctl,
  output logic signed [15:0]      sample_val
);
  import adpcm_pkg::*;

  logic signed [15:0] history_newest;
  logic signed [15:0] history_older;
  logic signed [23:0] prod;
  logic signed [18:0] acc;

  logic signed [15:0] opa;
  logic signed [7:0]  coef;
  logic signed [17:0] term;
  logic signed [15:0] base_raw;
  logic signed [15:0] base_sh;
  logic signed [19:0] sum;

  // Select the operands of the shared multiplier
  always_comb begin
    if (ctl.op == MAC_NEG) begin
      opa  = history_older;
      coef = coef_neg(ctl.filter);
    end else begin
      opa  = history_newest;
      coef = coef_pos(ctl.filter);
    end
  end

  // Scale the nibble and the registered product
  assign base_raw = {ctl.nibble, 12'h000};
  assign base_sh  = base_raw >>> ctl.shift;
  assign term     = $signed(prod[23:6]);
  assign sum      = 20'(acc) + 20'(term);

  // Saturate to 16 bits
  always_comb begin
    if (sum > SAT_HI) begin
      sample_val = 16'sh7fff;
    end else if (sum < SAT_LO) begin
      sample_val = -16'sh8000;
    end else begin
      sample_val = sum[15:0];
    end
  end

  // Multiply and accumulate one term per step
  always_ff @(posedge clk) begin
    case (ctl.op)
      MAC_POS: begin
        prod <= opa * coef;
      end
      MAC_NEG: begin
        prod <= opa * coef;
        acc  <= 19'(base_sh) + 19'(term);
      end
      default: begin
      end
    endcase
  end

  // Shift the history on each delivered sample
  always_ff @(posedge clk) begin
    if (rst) begin
      history_newest <= '0;
      history_older  <= '0;
    end else if (ctl.commit) begin
      history_older  <= history_newest;
      history_newest <= sample_val;
    end
  end

endmodule

`default_nettype wire

// ----- sv/adpcm_seq.sv -----
`default_nettype none

module adpcm_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [15:0]          in_word,
  input  wire logic                 in_is_header,
  output logic                      in_ready,
  input  wire logic                 slot_free,
  output adpcm_pkg::mac_ctl_t       ctl,
  output adpcm_pkg::out_info_t      info
);
  import adpcm_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [15:0] word_reg;
  logic [1:0]  nib_idx;
  logic [3:0]  shift_amount;
  logic [2:0]  filter_select;
  logic [2:0]  loop_flags;
  logic [2:0]  data_word_count;

  logic        accept;
  logic        commit;
  mac_op_t     op;
  logic        last_nib;
  logic        last_word;
  logic [3:0]  hdr_shift;
  logic [2:0]  hdr_filter;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign last_nib  = (nib_idx == LAST_NIB_IDX);
  assign last_word = (data_word_count == LAST_WORD_IDX);
  assign hdr_shift  = (in_word[3:0] > SHIFT_LIMIT) ? SHIFT_SUBST : in_word[3:0];
  assign hdr_filter = (in_word[6:4] > FILTER_LIMIT) ? FILTER_LIMIT : in_word[6:4];

  // Next state and unit control
  always_comb begin
    state_next = state;
    commit     = 1'b0;
    op         = MAC_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (accept && !in_is_header) begin
          state_next = ST_MUL_POS;
        end
      end
      ST_MUL_POS: begin
        op         = MAC_POS;
        state_next = ST_MUL_NEG;
      end
      ST_MUL_NEG: begin
        op         = MAC_NEG;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        op = MAC_FINISH;
        if (slot_free) begin
          commit     = 1'b1;
          state_next = last_nib ? ST_IDLE : ST_MUL_POS;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign ctl.op     = op;
  assign ctl.nibble = word_reg[{nib_idx, 2'b00} +: 4];
  assign ctl.shift  = shift_amount;
  assign ctl.filter = filter_select;
  assign ctl.commit = commit;

  assign info.commit       = commit;
  assign info.loop_flags   = loop_flags;
  assign info.last_of_word = last_nib;
  assign info.block_done   = last_nib && last_word;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch header fields, step the nibble index and count data words
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount    <= '0;
      filter_select   <= '0;
      loop_flags      <= '0;
      data_word_count <= '0;
      nib_idx         <= '0;
    end else if (accept) begin
      nib_idx <= '0;
      if (in_is_header) begin
        shift_amount    <= hdr_shift;
        filter_select   <= hdr_filter;
        loop_flags      <= in_word[10:8];
        data_word_count <= '0;
      end
    end else if (commit) begin
      nib_idx <= nib_idx + 2'd1;
      if (last_nib) begin
        data_word_count <= last_word ? 3'd0 : data_word_count + 3'd1;
      end
    end
  end

  // Hold the data word while its nibbles are decoded
  always_ff @(posedge clk) begin
    if (accept && !in_is_header) begin
      word_reg <= in_word;
    end
  end

endmodule

`default_nettype wire
